>>> rtl/sha256_block_compress_core_macros.svh
// assertion macros shared by the sha-256 compression core
`ifndef SHA256_BLOCK_COMPRESS_CORE_MACROS_SVH
`define SHA256_BLOCK_COMPRESS_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SHA_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition in this cycle implies condition in the next cycle
`define SHA_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

>>> rtl/sha256bc_pkg.sv
// shared types, constants and round table for the sha-256 compression core
package sha256bc_pkg;

    typedef logic [31:0] t_word;
    typedef logic [5:0]  t_round_idx;

    localparam t_round_idx LastRound = 6'd63;

    localparam t_word InitHash [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundConst [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       start;
        logic       round;
        logic       finish;
        t_round_idx round_idx;
    } t_dp_cmd;

endpackage

>>> rtl/sha256_block_compress_core.sv
// sha-256 block compression core top level
// a block is taken only in idle, then goes through the rounds and a final add into the digest
// register in the single shared round unit; the next block waits until that final add is done
// a new block is taken while the previous digest waits in the output register
// the final add stalls only if that digest has still not been taken
// reset (synchronous, active low) loads the initial hash and clears control state
module sha256_block_compress_core
    import sha256bc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_block_words_0_1,
    input  logic [63:0] i_block_words_2_3,
    input  logic [63:0] i_block_words_4_5,
    input  logic [63:0] i_block_words_6_7,
    input  logic [63:0] i_block_words_8_9,
    input  logic [63:0] i_block_words_10_11,
    input  logic [63:0] i_block_words_12_13,
    input  logic [63:0] i_block_words_14_15,
    input  logic        i_start_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_words_0_1,
    output logic [63:0] o_digest_words_2_3,
    output logic [63:0] o_digest_words_4_5,
    output logic [63:0] o_digest_words_6_7
);

    t_dp_cmd      cmd;
    logic [511:0] block;
    logic [255:0] digest;

    // word 0 sits in the top bits of the packed block
    assign block = {i_block_words_0_1, i_block_words_2_3, i_block_words_4_5,
                    i_block_words_6_7, i_block_words_8_9, i_block_words_10_11,
                    i_block_words_12_13, i_block_words_14_15};

    // controller owns the round counter and output valid
    sha256bc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_start     (i_start_of_message),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // datapath holds schedule, working variables, chaining value and digest
    sha256bc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_block  (block),
        .o_digest (digest)
    );

    assign o_digest_words_0_1 = digest[255:192];
    assign o_digest_words_2_3 = digest[191:128];
    assign o_digest_words_4_5 = digest[127:64];
    assign o_digest_words_6_7 = digest[63:0];

endmodule

>>> rtl/sha256bc_dp.sv
// sha-256 datapath: schedule window, working variables, chaining value, digest register
module sha256bc_dp
    import sha256bc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_dp_cmd        i_cmd,
    input  logic [511:0]   i_block,
    output logic [255:0]   o_digest
);

    t_word        r_win   [0:15];
    t_word        r_var   [0:7];
    t_word        r_chain [0:7];
    logic [255:0] r_digest;

    t_word new_w;
    t_word t1;
    t_word t2;
    t_word sum [0:7];

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        new_w = (rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10))
              + r_win[9]
              + (rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3))
              + r_win[0];
        t1 = r_var[7]
           + (rotr(r_var[4], 6) ^ rotr(r_var[4], 11) ^ rotr(r_var[4], 25))
           + ((r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]))
           + RoundConst[i_cmd.round_idx]
           + r_win[0];
        t2 = (rotr(r_var[0], 2) ^ rotr(r_var[0], 13) ^ rotr(r_var[0], 22))
           + ((r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]));
        for (int i = 0; i < 8; i++) begin
            sum[i] = r_chain[i] + r_var[i];
        end
    end

    // chaining value, reset to the initial hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= InitHash[i];
        end else if (i_cmd.load && i_cmd.start) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= InitHash[i];
        end else if (i_cmd.finish) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= sum[i];
        end
    end

    // window holds w[t..t+15]; the front word feeds round t
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 16; i++) r_win[i] <= i_block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) begin
                r_var[i] <= i_cmd.start ? InitHash[i] : r_chain[i];
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
            r_win[15] <= new_w;
            r_var[7] <= r_var[6];
            r_var[6] <= r_var[5];
            r_var[5] <= r_var[4];
            r_var[4] <= r_var[3] + t1;
            r_var[3] <= r_var[2];
            r_var[2] <= r_var[1];
            r_var[1] <= r_var[0];
            r_var[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_digest <= {sum[0], sum[1], sum[2], sum[3], sum[4], sum[5], sum[6], sum[7]};
        end
    end

    assign o_digest = r_digest;

endmodule

>>> rtl/sha256bc_ctrl.sv
// sha-256 controller: round sequencing and output handshake
module sha256bc_ctrl
    import sha256bc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_start,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

`include "sha256_block_compress_core_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ROUND = 3'b010,
        S_FINAL = 3'b100
    } t_state;

    t_state     r_state, n_state;
    t_round_idx r_round, n_round;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_in_ready       = (r_state == S_IDLE);
        o_cmd.load       = i_in_valid && o_in_ready;
        o_cmd.start      = i_start;
        o_cmd.round      = (r_state == S_ROUND);
        o_cmd.finish     = (r_state == S_FINAL) && (!r_out_valid || i_out_ready);
        o_cmd.round_idx  = r_round;

        n_state = r_state;
        n_round = r_round;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_ROUND;
                    n_round = '0;
                end
            end
            S_ROUND: begin
                n_round = r_round + 6'd1;
                if (r_round == LastRound) n_state = S_FINAL;
            end
            S_FINAL: begin
                if (o_cmd.finish) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.finish)     n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SHA_ASSERT_NEXT(a_finish_sets_valid, o_cmd.finish, r_out_valid, "finish did not raise output valid")
    `SHA_ASSERT_NEXT(a_last_round_final, o_cmd.round && r_round == LastRound, r_state == S_FINAL, "no final step after last round")
    `SHA_ASSERT_HOLDS(a_no_load_busy, !(o_cmd.load && (o_cmd.round || o_cmd.finish)), "transaction accepted while busy")

endmodule

>>> sim/tb_sha256_block_compress_core.sv
// testbench for the sha-256 block compression core: known answers, chained random blocks
module tb_sha256_block_compress_core
    import sha256bc_pkg::*;
();

    localparam int NumRows    = 12;
    localparam int TotalItems = 1950;

    // standard initial hash value, H0 in the top word
    localparam logic [255:0] InitChain =
        256'h6a09e667bb67ae853c6ef372a54ff53a510e527f9b05688c1f83d9ab5be0cd19;

    // padded single blocks and the two blocks of the 56-byte test message
    localparam logic [511:0] BlkAbc   = {32'h61626380, 448'h0, 32'h00000018};
    localparam logic [511:0] BlkEmpty = {32'h80000000, 480'h0};
    localparam logic [511:0] BlkLong1 = {
        256'h6162636462636465636465666465666765666768666768696768696a68696a6b,
        256'h696a6b6c6a6b6c6d6b6c6d6e6c6d6e6f6d6e6f706e6f70718000000000000000};
    localparam logic [511:0] BlkLong2 = {480'h0, 32'h000001c0};

    localparam logic [255:0] DigAbc   =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;
    localparam logic [255:0] DigEmpty =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] DigLong  =
        256'h248d6a61d20638b8e5c026930c3e6039a33ce45964ff2167f6ecedd419db06c1;

    typedef struct packed {
        logic [511:0] words;
        logic         sof;
        logic         known;
        logic [255:0] digest;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_block_words_0_1;
    logic [63:0] i_block_words_2_3;
    logic [63:0] i_block_words_4_5;
    logic [63:0] i_block_words_6_7;
    logic [63:0] i_block_words_8_9;
    logic [63:0] i_block_words_10_11;
    logic [63:0] i_block_words_12_13;
    logic [63:0] i_block_words_14_15;
    logic        i_start_of_message;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_digest_words_0_1;
    logic [63:0] o_digest_words_2_3;
    logic [63:0] o_digest_words_4_5;
    logic [63:0] o_digest_words_6_7;

    logic [255:0] chain_value;
    logic [255:0] pending_digests [$];
    t_stim_row    stim_rows [0:NumRows-1];
    int           mismatch_count = 0;
    int           blocks_sent = 0;

    sha256_block_compress_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_block_words_0_1  (i_block_words_0_1),
        .i_block_words_2_3  (i_block_words_2_3),
        .i_block_words_4_5  (i_block_words_4_5),
        .i_block_words_6_7  (i_block_words_6_7),
        .i_block_words_8_9  (i_block_words_8_9),
        .i_block_words_10_11(i_block_words_10_11),
        .i_block_words_12_13(i_block_words_12_13),
        .i_block_words_14_15(i_block_words_14_15),
        .i_start_of_message (i_start_of_message),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_digest_words_0_1 (o_digest_words_0_1),
        .o_digest_words_2_3 (o_digest_words_2_3),
        .o_digest_words_4_5 (o_digest_words_4_5),
        .o_digest_words_6_7 (o_digest_words_6_7)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_s0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_s0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_s1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // one compression: full 64-entry schedule, 64 rounds, feed-forward add
    function automatic logic [255:0] sha_compress(input logic [255:0] h_in,
                                                  input logic [511:0] blk);
        t_word        w [0:63];
        t_word        v [0:7];
        t_word        t1;
        t_word        t2;
        logic [255:0] h_out;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 64; i++)
            w[i] = small_s1(w[i - 2]) + w[i - 7] + small_s0(w[i - 15]) + w[i - 16];
        for (int i = 0; i < 8; i++) v[i] = h_in[255 - 32 * i -: 32];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
            t2 = big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) h_out[255 - 32 * i -: 32] = h_in[255 - 32 * i -: 32] + v[i];
        return h_out;
    endfunction

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap(input bit calm, input int long_max);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(15, long_max);
    endfunction

    function automatic t_word rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4) return t_word'(1) << $urandom_range(0, 31);
        return $urandom;
    endfunction

    function automatic logic [511:0] rand_block();
        logic [511:0] blk;
        for (int i = 0; i < 16; i++) blk[511 - 32 * i -: 32] = rand_word();
        return blk;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %h, actual %h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    task automatic check_digest();
        logic [255:0] exp_dig;
        if (pending_digests.size() == 0) begin
            $error("digest transaction with no block outstanding");
            mismatch_count++;
        end else begin
            exp_dig = pending_digests.pop_front();
            check_field("digest_words_0_1", exp_dig[255:192], o_digest_words_0_1);
            check_field("digest_words_2_3", exp_dig[191:128], o_digest_words_2_3);
            check_field("digest_words_4_5", exp_dig[127:64],  o_digest_words_4_5);
            check_field("digest_words_6_7", exp_dig[63:0],    o_digest_words_6_7);
        end
    endtask

    // called at a rising edge; returns at the edge where the block is taken
    task automatic send_block(input logic [511:0] blk, input logic sof, input logic known,
                              input logic [255:0] known_dig);
        int  gap;
        // every fourth stretch of 64 blocks goes out back to back
        gap = pick_gap(((blocks_sent / 64) % 4) == 3, 40);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_block_words_0_1, i_block_words_2_3, i_block_words_4_5, i_block_words_6_7,
         i_block_words_8_9, i_block_words_10_11, i_block_words_12_13,
         i_block_words_14_15} <= blk;
        i_start_of_message <= sof;
        do @(posedge i_clk); while (!o_in_ready);
        if (sof) chain_value = InitChain;
        chain_value = sha_compress(chain_value, blk);
        pending_digests.push_back(known ? known_dig : chain_value);
        blocks_sent++;
    endtask

    // hold the sender off until every digest has been taken
    task automatic wait_all_digests();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_digests.size() != 0);
    endtask

    // digest side: random stalls, with calm stretches of ready held high
    initial begin : digest_sink
        int stall;
        int cycle_cnt;
        stall = 0;
        cycle_cnt = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_digest();
                stall = pick_gap(((cycle_cnt / 5000) % 3) == 2, 120);
            end else if (stall == 0 && $urandom_range(0, 19) == 0) begin
                stall = pick_gap(((cycle_cnt / 5000) % 3) == 2, 120);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : block_source
        int   n_blk;
        logic sof;
        // known answers, chaining without a start, restart in mid-message, extremes
        stim_rows[0]  = '{BlkAbc,              1'b0, 1'b1, DigAbc};
        stim_rows[1]  = '{BlkEmpty,            1'b1, 1'b1, DigEmpty};
        stim_rows[2]  = '{BlkLong1,            1'b1, 1'b0, '0};
        stim_rows[3]  = '{BlkLong2,            1'b0, 1'b1, DigLong};
        stim_rows[4]  = '{{512{1'b1}},         1'b1, 1'b0, '0};
        stim_rows[5]  = '{{512{1'b0}},         1'b0, 1'b0, '0};
        stim_rows[6]  = '{{512{1'b1}},         1'b0, 1'b0, '0};
        stim_rows[7]  = '{BlkLong1,            1'b1, 1'b0, '0};
        stim_rows[8]  = '{BlkAbc,              1'b1, 1'b1, DigAbc};
        stim_rows[9]  = '{{16{32'haaaaaaaa}},  1'b0, 1'b0, '0};
        stim_rows[10] = '{{16{32'h55555555}},  1'b1, 1'b0, '0};
        stim_rows[11] = '{BlkEmpty,            1'b1, 1'b1, DigEmpty};

        chain_value = InitChain;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_start_of_message <= 1'b0;
        {i_block_words_0_1, i_block_words_2_3, i_block_words_4_5, i_block_words_6_7,
         i_block_words_8_9, i_block_words_10_11, i_block_words_12_13,
         i_block_words_14_15} <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NumRows; r++)
            send_block(stim_rows[r].words, stim_rows[r].sof, stim_rows[r].known,
                       stim_rows[r].digest);
        wait_all_digests();

        // random messages of chained blocks, mostly short, with stray starts and restarts
        while (blocks_sent < TotalItems) begin
            n_blk = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            for (int k = 0; k < n_blk; k++) begin
                sof = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
                send_block(rand_block(), sof, 1'b0, '0);
            end
            if ($urandom_range(0, 49) == 0) wait_all_digests();
        end

        wait_all_digests();
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #50000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/sha256bc_pkg.sv
rtl/sha256bc_dp.sv
rtl/sha256bc_ctrl.sv
rtl/sha256_block_compress_core.sv
sim/tb_sha256_block_compress_core.sv
